[rtl/lws_pkg.sv]
// Shared types and constants for the lexer with symbol table.
`timescale 1ns / 1ps
package lws_pkg;

  typedef enum logic [2:0] {
    KIND_ID      = 3'd0,
    KIND_KEYWORD = 3'd1,
    KIND_NUM     = 3'd2,
    KIND_OP      = 3'd3,
    KIND_SPECIAL = 3'd4,
    KIND_FUN     = 3'd5
  } kind_t;

  localparam logic [2:0] KW_NONE   = 3'd0;
  localparam logic [2:0] KW_MAIN   = 3'd1;
  localparam logic [2:0] KW_INT    = 3'd2;
  localparam logic [2:0] KW_CHAR   = 3'd3;
  localparam logic [2:0] KW_RETURN = 3'd4;
  localparam logic [2:0] KW_FUNC   = 3'd5;
  localparam logic [2:0] TYPE_FUNC = 3'd6;

  // Token handed from the scanner to the symbol stage.
  typedef struct packed {
    kind_t       kind;
    logic [63:0] text;
    logic [3:0]  len;
    logic        ovf;
    logic [7:0]  scope;
    logic        last;
  } tok_t;

  // Finished result.
  typedef struct packed {
    logic [2:0]  kind;
    logic [63:0] text;
    logic [3:0]  len;
    logic        ovf;
    logic [2:0]  kw;
    logic [4:0]  id;
    logic        isnew;
    logic [2:0]  stype;
    logic [2:0]  ssize;
    logic [7:0]  sscope;
    logic [2:0]  sret;
    logic        last;
  } res_t;

  function automatic logic [2:0] keyword_of(input logic [63:0] t);
    logic [2:0] k;
    k = KW_NONE;
    unique case (t)
      64'h6E69616D:       k = KW_MAIN;
      64'h746E69:         k = KW_INT;
      64'h72616863:       k = KW_CHAR;
      64'h6E72757465_72:  k = KW_RETURN;
      64'h636E7566:       k = KW_FUNC;
      default:            k = KW_NONE;
    endcase
    return k;
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
  endfunction
  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction
  function automatic logic is_special(input logic [7:0] c);
    return c == 8'h5B || c == 8'h5D || c == 8'h7B || c == 8'h7D || c == 8'h28 ||
           c == 8'h29 || c == 8'h2C || c == 8'h3B || c == 8'h3A || c == 8'h2E ||
           c == 8'h23;
  endfunction
  function automatic logic is_operator(input logic [7:0] c);
    return c == 8'h2B || c == 8'h2D || c == 8'h2A || c == 8'h2F || c == 8'h25 ||
           c == 8'h3C || c == 8'h3E || c == 8'h3D || c == 8'h21 || c == 8'h26 ||
           c == 8'h7C || c == 8'h5E || c == 8'h7E;
  endfunction

endpackage

[rtl/lws_scan.sv]
// Front end: character classifier and token builder.
`timescale 1ns / 1ps
module lws_scan #(
  parameter int MAX_CHARS  = 8,
  parameter int SCOPE_BITS = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  output logic          full,
  input  logic [7:0]    ch,
  input  logic          end_of_input,
  output logic          tok_valid,
  input  logic          tok_ready,
  output lws_pkg::tok_t tok
);

  typedef enum logic [3:0] {
    M_IDLE  = 4'b0001,
    M_IDENT = 4'b0010,
    M_NUM   = 4'b0100,
    M_OP    = 4'b1000
  } mode_t;

  localparam logic signed [SCOPE_BITS-1:0] SMAX = {1'b0, {(SCOPE_BITS-1){1'b1}}};
  localparam logic signed [SCOPE_BITS-1:0] SMIN = {1'b1, {(SCOPE_BITS-1){1'b0}}};

  mode_t mode, mode_next;
  logic [63:0] text, text_next;
  logic [3:0]  len, len_next;
  logic        ovf, ovf_next;
  logic signed [SCOPE_BITS-1:0] scope, scope_next;

  // Second token of a byte waits here.
  logic          hold;
  lws_pkg::tok_t hold_tok;

  lws_pkg::tok_t t0, t1;
  logic v0, v1;
  logic take;

  assign full = hold || (tok_valid && !tok_ready);
  assign take = push && !full;

  always_comb begin
    logic fl, fun, appended, cont;
    mode_next  = mode;
    text_next  = text;
    len_next   = len;
    ovf_next   = ovf;
    scope_next = scope;
    fl = 1'b0; fun = 1'b0; cont = 1'b0; appended = 1'b0;
    v0 = 1'b0; v1 = 1'b0;
    t0 = '0; t1 = '0;
    if (end_of_input) begin
      fl = (mode != M_IDLE);
    end else begin
      unique case (mode)
        M_IDENT: begin
          if (lws_pkg::is_letter(ch) || lws_pkg::is_digit(ch) || ch == 8'h5F) cont = 1'b1;
          else begin fl = 1'b1; fun = (ch == 8'h28); end
        end
        M_NUM: begin
          if (lws_pkg::is_digit(ch) || ch == 8'h2E || ch == 8'h65 || ch == 8'h45) cont = 1'b1;
          else fl = 1'b1;
        end
        M_OP: begin
          if (lws_pkg::is_operator(ch)) cont = 1'b1;
          else if (ch == 8'h20 || ch == 8'h09) appended = 1'b1;
          else fl = 1'b1;
        end
        default: ;
      endcase
    end
    if (fl) begin
      v0 = 1'b1;
      t0.kind = (mode == M_IDENT) ? (fun ? lws_pkg::KIND_FUN : lws_pkg::KIND_ID) :
                (mode == M_NUM) ? lws_pkg::KIND_NUM : lws_pkg::KIND_OP;
      t0.text = text; t0.len = len; t0.ovf = ovf;
      t0.scope = 8'(scope);
      mode_next = M_IDLE; text_next = '0; len_next = '0; ovf_next = 1'b0;
    end
    if (cont) begin
      if (len < 4'(MAX_CHARS)) begin
        text_next = text | (64'(ch) << {len[2:0], 3'b000});
        len_next  = len + 4'd1;
      end else ovf_next = 1'b1;
    end else if (!end_of_input && !appended) begin
      if (lws_pkg::is_letter(ch) || lws_pkg::is_digit(ch) ||
          (ch != 8'h00 && lws_pkg::is_operator(ch))) begin
        mode_next = lws_pkg::is_letter(ch) ? M_IDENT :
                    lws_pkg::is_digit(ch) ? M_NUM : M_OP;
        text_next = 64'(ch); len_next = 4'd1; ovf_next = 1'b0;
      end else if (lws_pkg::is_special(ch)) begin
        if (ch == 8'h7B && scope < SMAX) scope_next = scope + 1'b1;
        else if (ch == 8'h7D && scope > SMIN) scope_next = scope - 1'b1;
        v1 = 1'b1;
        t1.kind = lws_pkg::KIND_SPECIAL;
        t1.text = 64'(ch); t1.len = 4'd1; t1.ovf = 1'b0; t1.scope = '0;
      end
    end
    t0.last = !v1;
    t1.last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= M_IDLE; text <= '0; len <= '0; ovf <= 1'b0; scope <= '0;
      tok_valid <= 1'b0; hold <= 1'b0;
    end else begin
      if (tok_valid && tok_ready) begin
        tok_valid <= hold;
        tok <= hold_tok;
        hold <= 1'b0;
      end
      if (take) begin
        mode <= mode_next; text <= text_next; len <= len_next;
        ovf <= ovf_next; scope <= scope_next;
        if (v0 || v1) begin
          tok_valid <= 1'b1;
          tok <= v0 ? t0 : t1;
          hold <= v0 && v1;
          hold_tok <= t1;
        end
      end
    end
  end

endmodule

[rtl/lws_symtab.sv]
// Back end: keyword match and symbol table lookup and insert.
`timescale 1ns / 1ps
module lws_symtab #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          tok_valid,
  output logic          tok_ready,
  input  lws_pkg::tok_t tok,
  output logic          res_valid,
  input  logic          res_ready,
  output lws_pkg::res_t res
);

  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_OUT  = 3'b100
  } st_t;

  st_t st;
  lws_pkg::tok_t cur;
  lws_pkg::tok_t tok_in;
  logic [2:0]  tok_kw;
  logic        tok_is_kw;
  logic [63:0] names [TABLE_DEPTH];
  logic [16:0] attrs [TABLE_DEPTH];
  logic [63:0] rd_name;
  logic [16:0] rd_attr;
  logic [CW-1:0] count, idx;
  logic        rd_ok;
  logic [CW-1:0] rd_idx;
  logic [2:0]  last_kw;
  logic [16:0] new_attr;
  logic [2:0]  ksz;

  // A new token is taken only while the result register is empty, so a
  // finished lookup never has to wait for the output side.
  assign tok_ready = (st == S_IDLE) && !res_valid;

  assign tok_kw    = lws_pkg::keyword_of(tok.text);
  assign tok_is_kw = (tok.kind == lws_pkg::KIND_ID) && !tok.ovf &&
                     (tok_kw != lws_pkg::KW_NONE);

  always_comb begin
    tok_in = tok;
    if (tok_is_kw) tok_in.kind = lws_pkg::KIND_KEYWORD;
  end

  assign ksz = (last_kw == lws_pkg::KW_INT) ? 3'd4 :
               (last_kw == lws_pkg::KW_CHAR) ? 3'd1 : 3'd0;
  assign new_attr = (cur.kind == lws_pkg::KIND_FUN) ?
                    {last_kw, cur.scope, 3'd0, lws_pkg::TYPE_FUNC} :
                    {3'd0, cur.scope, ksz, last_kw};

  // One entry is read per cycle; table walked from the oldest entry.
  always_ff @(posedge clk) begin
    rd_name <= names[idx[IW-1:0]];
    rd_attr <= attrs[idx[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_IDLE; count <= '0; last_kw <= lws_pkg::KW_NONE;
      res_valid <= 1'b0; rd_ok <= 1'b0;
    end else begin
      if (res_valid && res_ready) res_valid <= 1'b0;
      unique case (st)
        S_IDLE: if (tok_valid && tok_ready) begin
          cur <= tok_in; idx <= '0; rd_ok <= 1'b0;
          if (tok_is_kw) begin
            last_kw <= tok_kw;
            st <= S_OUT;
          end else if (tok.kind == lws_pkg::KIND_ID || tok.kind == lws_pkg::KIND_FUN)
            st <= S_SCAN;
          else st <= S_OUT;
        end
        S_SCAN: begin
          // rd_name holds entry rd_idx when rd_ok is set.
          if (rd_ok && rd_name == cur.text) begin
            res.kind <= 3'(cur.kind); res.text <= cur.text; res.len <= cur.len;
            res.ovf <= cur.ovf; res.kw <= '0; res.id <= 5'(rd_idx + 1'b1);
            res.isnew <= 1'b0; res.stype <= rd_attr[2:0]; res.ssize <= rd_attr[5:3];
            res.sscope <= rd_attr[13:6]; res.sret <= rd_attr[16:14]; res.last <= cur.last;
            st <= S_IDLE; res_valid <= 1'b1;
          end else if (idx >= count && (!rd_ok || rd_idx + 1'b1 >= count)) begin
            res.kind <= 3'(cur.kind); res.text <= cur.text; res.len <= cur.len;
            res.ovf <= cur.ovf; res.kw <= '0; res.last <= cur.last;
            if (count < CW'(TABLE_DEPTH)) begin
              names[count[IW-1:0]] <= cur.text;
              attrs[count[IW-1:0]] <= new_attr;
              count <= count + 1'b1;
              res.id <= 5'(count + 1'b1); res.isnew <= 1'b1;
              res.stype <= new_attr[2:0]; res.ssize <= new_attr[5:3];
              res.sscope <= new_attr[13:6]; res.sret <= new_attr[16:14];
            end else begin
              res.id <= '0; res.isnew <= 1'b0; res.stype <= '0; res.ssize <= '0;
              res.sscope <= '0; res.sret <= '0;
            end
            st <= S_IDLE; res_valid <= 1'b1;
          end else begin
            rd_ok  <= (idx < count);
            rd_idx <= idx;
            if (idx < count) idx <= idx + 1'b1;
          end
        end
        S_OUT: if (!res_valid || res_ready) begin
          res.kind <= 3'(cur.kind); res.text <= cur.text; res.len <= cur.len;
          res.ovf <= cur.ovf;
          res.kw <= (cur.kind == lws_pkg::KIND_KEYWORD) ? lws_pkg::keyword_of(cur.text) : '0;
          res.id <= '0; res.isnew <= 1'b0; res.stype <= '0; res.ssize <= '0;
          res.sscope <= '0; res.sret <= '0; res.last <= cur.last;
          res_valid <= 1'b1; st <= S_IDLE;
        end
        default: st <= S_IDLE;
      endcase
    end
  end

endmodule

[rtl/lexer_with_symbol_table_unit.sv]
// Top level of the lexer with symbol table.
// A byte that ends a run is registered as a token in the scanner; the symbol stage
// then takes it and registers the result directly for keywords, numbers, operators
// and specials, or after walking the table up to a match for identifiers. A token
// waits while the previous result is unpopped. Throughput: one byte per cycle while
// full is low; the symbol walk and each pop set the pace when tokens are emitted.
// Reset (rst, synchronous) empties the table and clears all scanner state.
`timescale 1ns / 1ps
module lexer_with_symbol_table_unit #(
  parameter int TABLE_DEPTH = 16,
  parameter int MAX_CHARS   = 8,
  parameter int SCOPE_BITS  = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  logic [7:0]        ch,
  input  logic              end_of_input,
  output logic              empty,
  input  logic              pop,
  output logic [2:0]        tok_kind,
  output logic [63:0]       tok_text,
  output logic [3:0]        tok_len,
  output logic              truncated,
  output logic [2:0]        keyword_code,
  output logic [4:0]        sym_id,
  output logic              sym_new,
  output logic [2:0]        sym_type,
  output logic [2:0]        sym_size,
  output logic signed [7:0] sym_scope,
  output logic [2:0]        sym_return,
  output logic              last_of_run
);

  // The scanner hands finished tokens across a token register with one spare
  // slot for the second token of a byte; the symbol stage holds the token
  // while it walks the table.
  lws_pkg::tok_t tok;
  lws_pkg::res_t res;
  logic tok_valid, tok_ready, res_valid;

  lws_scan #(.MAX_CHARS(MAX_CHARS), .SCOPE_BITS(SCOPE_BITS)) u_scan (
    .clk, .rst, .push, .full, .ch, .end_of_input,
    .tok_valid, .tok_ready, .tok
  );

  lws_symtab #(.TABLE_DEPTH(TABLE_DEPTH)) u_sym (
    .clk, .rst, .tok_valid, .tok_ready, .tok,
    .res_valid, .res_ready(pop), .res
  );

  assign empty        = !res_valid;
  assign tok_kind     = res.kind;
  assign tok_text     = res.text;
  assign tok_len      = res.len;
  assign truncated    = res.ovf;
  assign keyword_code = res.kw;
  assign sym_id       = res.id;
  assign sym_new      = res.isnew;
  assign sym_type     = res.stype;
  assign sym_size     = res.ssize;
  assign sym_scope    = res.sscope;
  assign sym_return   = res.sret;
  assign last_of_run  = res.last;

endmodule

[rtl/lws_checker.sv]
// Port-level checker for the lexer with symbol table.
`timescale 1ns / 1ps
module lws_checker (
  input logic       clk,
  input logic       rst,
  input logic       empty,
  input logic       pop,
  input logic [3:0] tok_len,
  input logic [2:0] tok_kind,
  input logic       sym_new,
  input logic [4:0] sym_id
);
  a_len: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (tok_len != 4'd0)) else $error("zero length token");
  a_new: assert property (@(posedge clk) disable iff (rst)
    (!empty && sym_new) |-> (sym_id != 5'd0)) else $error("new entry without id");
  a_sym: assert property (@(posedge clk) disable iff (rst)
    (!empty && sym_id != 5'd0) |->
      (tok_kind == lws_pkg::KIND_ID || tok_kind == lws_pkg::KIND_FUN))
    else $error("symbol on non-symbol token");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> !empty) else $error("result dropped");
endmodule

bind lexer_with_symbol_table_unit lws_checker u_chk (
  .clk, .rst, .empty, .pop, .tok_len, .tok_kind, .sym_new, .sym_id
);
